FILE: rtl/stack_machine_executor_unit_macros.svh
// assertion helpers used by the executor unit rtl
// both expect clk and rst_n in scope
`ifndef STACK_MACHINE_EXECUTOR_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define SME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sme_pkg.sv
`default_nettype none

package sme_pkg;

    localparam int DATA_W              = 32;
    localparam int DEPTH_W             = 9;
    localparam int DEFAULT_STACK_DEPTH = 256;

    // instruction codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_BINOP = 2'd2;
    localparam logic [1:0] CMD_PRINT = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_BADOP     = 3'd4;

    // ascii operators
    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;
    localparam logic [7:0] OP_REM = 8'h25;

    typedef logic [DATA_W-1:0]  word_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [DATA_W-1:0]  push_value;
        logic [7:0]                operator_char;
        logic                      last_instruction;
    } instr_t;

    typedef struct packed {
        logic                      print_valid;
        logic signed [DATA_W-1:0]  print_value;
        logic [2:0]                status;
        depth_t                    stack_depth;
    } result_t;

    typedef struct packed {
        logic  start;
        logic  is_rem;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/sme_stream_if.sv
`default_nettype none

interface sme_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/stack_machine_executor_unit.sv
// stack machine executor: one instruction per request on the instr channel
// instr carries command, push_value, operator_char and last_instruction;
// result returns exactly one request per instruction with print_valid,
// print_value, status and stack_depth (entries left after the step)
// both channels use valid/ready; a request moves when both are high
// the stack lives in a one-write two-read synchronous ram; both top entries
// are read at the accept edge; the update is written back when execute (or, for / and %, the divide wait) ends
// push, pop, print, + - and *: executed in the execute state, then the result
// passes through the pending register into the output register
// / and %: the execute state starts the radix-2 divider (one quotient bit per
// cycle over 32 bits plus sign fix-up) and the block waits for it in its
// divide state
// one instruction is in flight at a time; the next is taken as soon as the
// result sits in the output register, even if the receiver has not taken it
// a stalled receiver holds the result register and the block waits in its
// done state until the register frees up
// reset empties the stack (count to zero) and clears the result valid;
// the ram itself is not cleared since only live entries are ever read
`default_nettype none

`include "stack_machine_executor_unit_macros.svh"

module stack_machine_executor_unit #(
    parameter int STACK_DEPTH = sme_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sme_stream_if.sink    instr,
    sme_stream_if.source  result
);

    localparam int W      = sme_pkg::DATA_W;
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    sme_pkg::instr_t   cmd_reg;
    sme_pkg::result_t  pend_reg;
    sme_pkg::result_t  pend_next;
    sme_pkg::result_t  res_reg;
    logic              res_valid_reg;

    // stack ram
    logic [W-1:0]      stack_mem [STACK_DEPTH];
    logic [W-1:0]      rd_a_reg;
    logic [W-1:0]      rd_b_reg;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [W-1:0]      mem_wdata;

    sme_pkg::div_req_t div_req;
    sme_pkg::div_rsp_t div_rsp;

    logic              accept;
    logic              out_free;
    logic              op_known;
    logic              op_is_div;
    logic              full;
    logic              empty;
    logic              below_two;
    logic [W-1:0]      arith;

    assign accept   = instr.valid && instr.ready;
    assign out_free = !res_valid_reg || result.ready;

    // b is the top entry, a the one below it
    assign raddr_b = ADDR_W'(count_reg - CNT_W'(1));
    assign raddr_a = ADDR_W'(count_reg - CNT_W'(2));

    assign full      = (count_reg >= CNT_W'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign below_two = (count_reg < CNT_W'(2));

    assign op_known  = cmd_reg.operator_char inside {sme_pkg::OP_ADD, sme_pkg::OP_SUB,
        sme_pkg::OP_MUL, sme_pkg::OP_DIV, sme_pkg::OP_REM};
    assign op_is_div = cmd_reg.operator_char inside {sme_pkg::OP_DIV, sme_pkg::OP_REM};

    // add, subtract and multiply all wrap to the word width
    always_comb
    begin
        case (cmd_reg.operator_char)
            sme_pkg::OP_ADD: arith = rd_a_reg + rd_b_reg;
            sme_pkg::OP_SUB: arith = rd_a_reg - rd_b_reg;
            default:         arith = rd_a_reg * rd_b_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= stack_mem[raddr_a];
        rd_b_reg <= stack_mem[raddr_b];
    end

    sme_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // main sequencer
    always_comb
    begin
        logic [2:0]       status;
        logic             pvalid;
        logic [W-1:0]     pvalue;
        logic [CNT_W-1:0] cnt_after;
        logic             go_div;

        status     = sme_pkg::ST_OK;
        pvalid     = 1'b0;
        pvalue     = '0;
        cnt_after  = count_reg;
        go_div     = 1'b0;
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        mem_we     = 1'b0;
        mem_waddr  = raddr_a;
        mem_wdata  = arith;
        div_req.start    = 1'b0;
        div_req.is_rem   = (cmd_reg.operator_char == sme_pkg::OP_REM);
        div_req.dividend = rd_a_reg;
        div_req.divisor  = rd_b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.command)
                    sme_pkg::CMD_PUSH:
                    begin
                        if (full)
                        begin
                            status = sme_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(count_reg);
                            mem_wdata = cmd_reg.push_value;
                            cnt_after = count_reg + CNT_W'(1);
                        end
                    end
                    sme_pkg::CMD_POP:
                    begin
                        if (empty)
                        begin
                            status = sme_pkg::ST_UNDERFLOW;
                        end
                        else
                        begin
                            cnt_after = count_reg - CNT_W'(1);
                        end
                    end
                    sme_pkg::CMD_BINOP:
                    begin
                        // unknown operator wins over the depth check
                        if (!op_known)
                        begin
                            status = sme_pkg::ST_BADOP;
                        end
                        else if (below_two)
                        begin
                            status = sme_pkg::ST_UNDERFLOW;
                        end
                        else if (op_is_div && (rd_b_reg == '0))
                        begin
                            status = sme_pkg::ST_DIVZERO;
                        end
                        else if (op_is_div)
                        begin
                            go_div = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            cnt_after = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        if (empty)
                        begin
                            status = sme_pkg::ST_UNDERFLOW;
                        end
                        else
                        begin
                            pvalid    = 1'b1;
                            pvalue    = rd_b_reg;
                            cnt_after = count_reg - CNT_W'(1);
                        end
                    end
                endcase

                if (go_div)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    count_next            = cmd_reg.last_instruction ? '0 : cnt_after;
                    pend_next.print_valid = pvalid;
                    pend_next.print_value = pvalue;
                    pend_next.status      = status;
                    pend_next.stack_depth = sme_pkg::depth_t'(count_next);
                    state_next            = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = div_rsp.result;
                    count_next = cmd_reg.last_instruction ? '0
                                                          : (count_reg - CNT_W'(1));
                    pend_next.print_valid = 1'b0;
                    pend_next.print_value = '0;
                    pend_next.status      = sme_pkg::ST_OK;
                    pend_next.stack_depth = sme_pkg::depth_t'(count_next);
                    state_next            = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= instr.data;
        end
        pend_reg <= pend_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            res_reg <= pend_reg;
        end
    end

    assign instr.ready  = (state_reg == S_IDLE);
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    `SME_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CNT_W'(STACK_DEPTH),
        "stack count beyond depth")
    `SME_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC,
        "accepted instruction did not reach execute")
    `SME_ASSERT_SAME(a_div_done_in_div, div_rsp.done, state_reg == S_DIV,
        "divider finished outside the divide wait")
    `SME_ASSERT_SAME(a_write_when_busy, mem_we, (state_reg == S_EXEC) || (state_reg == S_DIV),
        "stack write outside execute or divide")

endmodule

`default_nettype wire

FILE: rtl/sme_div.sv
`default_nettype none

// radix-2 restoring divider on magnitudes, sign fixed up in a final step
module sme_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sme_pkg::div_req_t req,
    output sme_pkg::div_rsp_t     rsp
);

    localparam int W     = sme_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic             neg_reg;
    logic             is_rem_reg;
    logic [W-1:0]     result_reg;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic [W-1:0] sel;

    assign a_mag   = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
    assign b_mag   = req.divisor[W-1]  ? (W'(0) - req.divisor)  : req.divisor;
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign sel     = is_rem_reg ? rem_reg : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg    <= a_mag;
            rem_reg    <= '0;
            dvs_reg    <= b_mag;
            is_rem_reg <= req.is_rem;
            neg_reg    <= req.is_rem ? req.dividend[W-1]
                                     : (req.dividend[W-1] ^ req.divisor[W-1]);
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
        if (fin_reg)
        begin
            result_reg <= neg_reg ? (W'(0) - sel) : sel;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire
